### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

// Check a property at every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

### sv/kcv_pkg.sv
// Shared constants, types and register codes of the 3x3 convolution block.
package kcv_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int PIXEL_BITS   = 8;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS   = COL_BITS + 1;
    localparam int CFG_BITS     = 12;
    localparam int ROW_BITS     = CFG_BITS + 1;
    localparam int MAX_HEIGHT   = 4095;
    localparam int TAP_BITS     = 8;
    localparam int TAPS_ROW_BITS = 3 * TAP_BITS;
    localparam int PROD_BITS    = PIXEL_BITS + TAP_BITS + 1;
    localparam int ROW_SUM_BITS = PROD_BITS + 2;
    localparam int OUT_BITS     = 20;
    localparam int Q_DEPTH      = 4;
    localparam int Q_IDX        = $clog2(Q_DEPTH);
    localparam int Q_CNT        = Q_IDX + 1;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int LINE_BITS    = 2 * PIXEL_BITS;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(2048);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(4095);

    // Register index codes (byte address / 4)
    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_TAPS_TOP = 3'd2,
        REG_TAPS_MID = 3'd3,
        REG_TAPS_BOT = 3'd4
    } t_reg_idx;

    // Window and taps, entry r*3+c is row r (top first), column c (left first)
    typedef logic [8:0][PIXEL_BITS-1:0] t_window;
    typedef logic [8:0][TAP_BITS-1:0]   t_taps;

    // One result job handed from front to back
    typedef struct packed {
        t_window win;
        logic    interior;
        logic    last;
    } t_job;

endpackage

### sv/kcv_ram.sv
// Generic simple dual-port RAM with registered read.
module kcv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/kcv_front.sv
// Front end: input handshake, position tracking, line buffers and 3x3 window.
module kcv_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [kcv_pkg::PIXEL_BITS-1:0]    i_pixel,
    input  logic                              i_flush,
    input  logic [kcv_pkg::WIDTH_BITS-1:0]    i_width,
    input  logic [kcv_pkg::CFG_BITS-1:0]      i_height,
    input  logic [kcv_pkg::Q_CNT-1:0]         i_q_count,
    output logic                              o_push,
    output kcv_pkg::t_job                     o_push_job
);

    localparam int CB = kcv_pkg::COL_BITS;
    localparam int RB = kcv_pkg::ROW_BITS;
    localparam int WB = kcv_pkg::WIDTH_BITS;
    localparam int PB = kcv_pkg::PIXEL_BITS;

    logic [CB-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RB-1:0] r_in_row, n_in_row, r_out_row, n_out_row;

    logic          r_s1_valid;
    logic [PB-1:0] r_s1_px;
    logic [CB-1:0] r_s1_col;
    logic          r_s1_emit, r_s1_interior, r_s1_last;

    logic                          r_byp;
    logic [kcv_pkg::LINE_BITS-1:0] r_byp_data;

    kcv_pkg::t_window r_win, n_win;

    logic [kcv_pkg::Q_CNT:0]       pending;
    logic                          accept, draining, act, emit;
    logic                          in_wrap, out_col_end, out_row_end, interior, last;
    logic [RB-1:0]                 height_ext;
    logic [PB-1:0]                 px;
    logic [kcv_pkg::LINE_BITS-1:0] ram_rd, line_rd, line_wr;

    // Credit check: room in the queue for the word in flight and the new one
    assign pending    = (kcv_pkg::Q_CNT + 1)'(i_q_count) + (kcv_pkg::Q_CNT + 1)'(r_s1_valid);
    assign o_in_ready = pending < (kcv_pkg::Q_CNT + 1)'(kcv_pkg::Q_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    // Classify the word: flushes during the frame are dropped
    assign height_ext  = RB'(i_height);
    assign draining    = r_in_row >= height_ext;
    assign act         = accept && !(i_flush && !draining);
    assign px          = draining ? '0 : i_pixel;
    assign emit        = (r_in_row >= RB'(2)) || ((r_in_row == RB'(1)) && (r_in_col != '0));
    assign in_wrap     = (WB'(r_in_col) + WB'(1)) >= i_width;
    assign out_col_end = (WB'(r_out_col) + WB'(1)) >= i_width;
    assign out_row_end = (r_out_row + RB'(1)) >= height_ext;
    assign interior    = (r_out_row != '0) && !out_row_end && (r_out_col != '0) && !out_col_end;
    assign last        = out_row_end && out_col_end;

    // Advance input and output positions
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (act) begin
            if (in_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + RB'(1);
            end else begin
                n_in_col = r_in_col + CB'(1);
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + RB'(1);
                end else begin
                    n_out_col = r_out_col + CB'(1);
                end
            end
        end
    end

    // Line buffers: upper byte holds the upper line, lower byte the middle line
    kcv_ram #(
        .WIDTH (kcv_pkg::LINE_BITS),
        .DEPTH (kcv_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (line_wr),
        .i_raddr (r_in_col),
        .o_rdata (ram_rd)
    );

    // Forward a write to the same column issued in the read cycle
    assign line_rd = r_byp ? r_byp_data : ram_rd;
    assign line_wr = {line_rd[PB-1:0], r_s1_px};

    // Shift the window left and load the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = line_rd[kcv_pkg::LINE_BITS-1:PB];
        n_win[5] = line_rd[PB-1:0];
        n_win[8] = r_s1_px;
    end

    assign o_push              = r_s1_valid && r_s1_emit;
    assign o_push_job.win      = n_win;
    assign o_push_job.interior = r_s1_interior;
    assign o_push_job.last     = r_s1_last;

    // Hold positions, window and the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
            r_win      <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= act;
            r_byp      <= r_s1_valid && (r_s1_col == r_in_col);
            if (r_s1_valid) begin
                r_win <= n_win;
            end
        end
        r_byp_data    <= line_wr;
        r_s1_px       <= px;
        r_s1_col      <= r_in_col;
        r_s1_emit     <= emit;
        r_s1_interior <= interior;
        r_s1_last     <= last;
    end

endmodule

### sv/kcv_fifo.sv
// Short queue of result jobs between front and back.
module kcv_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  kcv_pkg::t_job             i_push_job,
    input  logic                      i_pop,
    output kcv_pkg::t_job             o_pop_job,
    output logic                      o_valid,
    output logic [kcv_pkg::Q_CNT-1:0] o_count
);

    kcv_pkg::t_job                   r_mem [kcv_pkg::Q_DEPTH];
    logic [kcv_pkg::Q_IDX-1:0]       r_wr_ptr, r_rd_ptr;
    logic [kcv_pkg::Q_CNT-1:0]       r_count;

    assign o_pop_job = r_mem[r_rd_ptr];
    assign o_valid   = r_count != '0;
    assign o_count   = r_count;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + kcv_pkg::Q_IDX'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + kcv_pkg::Q_IDX'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + kcv_pkg::Q_CNT'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - kcv_pkg::Q_CNT'(1);
            end
        end
    end

endmodule

### sv/kcv_back.sv
// Back end: multiply, row sums, total and the output register.
module kcv_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kcv_pkg::t_taps                       i_taps,
    input  logic                                 i_q_valid,
    output logic                                 o_pop,
    input  kcv_pkg::t_job                        i_job,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [kcv_pkg::OUT_BITS-1:0]  o_filtered,
    output logic                                 o_frame_end
);

    localparam int PRB = kcv_pkg::PROD_BITS;
    localparam int RSB = kcv_pkg::ROW_SUM_BITS;
    localparam int OB  = kcv_pkg::OUT_BITS;
    localparam int PB  = kcv_pkg::PIXEL_BITS;

    logic en;

    logic signed [PRB-1:0] prod [9];
    logic signed [PRB-1:0] r_a_prod [9];
    logic                  r_a_valid, r_a_interior, r_a_last;
    logic [PB-1:0]         r_a_center;

    logic signed [RSB-1:0] row_sum [3];
    logic signed [RSB-1:0] r_b_row [3];
    logic                  r_b_valid, r_b_interior, r_b_last;
    logic [PB-1:0]         r_b_center;

    logic signed [OB:0]    total;
    logic signed [OB-1:0]  result;
    logic                  r_c_valid, r_c_last;
    logic signed [OB-1:0]  r_c_value;

    // Move the whole pipe when the output register is free or being taken
    assign en    = !r_c_valid || i_out_ready;
    assign o_pop = en && i_q_valid;

    // Nine pixel-by-tap products
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            prod[i] = $signed({1'b0, i_job.win[i]}) * $signed(i_taps[i]);
        end
    end

    // Sum each kernel row
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = RSB'(r_a_prod[r*3]) + RSB'(r_a_prod[r*3 + 1])
                       + RSB'(r_a_prod[r*3 + 2]);
        end
    end

    // Total for interior positions, center pixel at the border
    assign total  = (OB + 1)'(r_b_row[0]) + (OB + 1)'(r_b_row[1]) + (OB + 1)'(r_b_row[2]);
    assign result = r_b_interior ? total[OB-1:0] : $signed(OB'(r_b_center));

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_q_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                r_a_prod[i] <= prod[i];
            end
            r_a_center   <= i_job.win[4];
            r_a_interior <= i_job.interior;
            r_a_last     <= i_job.last;
            for (int r = 0; r < 3; r++) begin
                r_b_row[r] <= row_sum[r];
            end
            r_b_center   <= r_a_center;
            r_b_interior <= r_a_interior;
            r_b_last     <= r_a_last;
            r_c_value    <= result;
            r_c_last     <= r_b_last;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_filtered  = r_c_value;
    assign o_frame_end = r_c_last;

endmodule

### sv/kernel_convolution_3x3.sv
// Top level of the 3x3 convolution block: register port, front, queue, back.
//
// Takes 8-bit grey pixels in raster order and returns, for each position, the
// signed 3x3 weighted sum with nine programmable signed 8-bit taps, or the
// pixel itself on the frame border. Results trail the input by one row plus
// one pixel; send width+1 flush words after a frame to drain it, and the last
// result of a frame carries frame_end. Sustained rate is one word per clock
// on both channels while the output is not stalled: the two line buffers share
// one MAX_WIDTH-entry RAM that takes one read and one write each cycle. A
// result leaves through the RAM read, queue, multiply, row sum and total
// registers after the word that releases it, and a four-entry queue lets the
// input keep running while the output stalls for a few cycles. Line buffer
// contents start undefined and need no clearing pass. Registers (32-bit APB,
// byte address 4*index): frame_width, frame_height, taps_top_row,
// taps_middle_row, taps_bottom_row; write them only while the block is idle.
module kernel_convolution_3x3 (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [kcv_pkg::PIXEL_BITS-1:0]       i_pixel,
    input  logic                                 i_flush,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [kcv_pkg::OUT_BITS-1:0]  o_filtered,
    output logic                                 o_frame_end,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kcv_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [kcv_pkg::DATA_BITS-1:0]        pwdata,
    output logic [kcv_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready
);

    localparam int CFB = kcv_pkg::CFG_BITS;
    localparam int TRB = kcv_pkg::TAPS_ROW_BITS;
    localparam int WB  = kcv_pkg::WIDTH_BITS;
    localparam int TB  = kcv_pkg::TAP_BITS;

    logic [CFB-1:0] r_frame_width, r_frame_height;
    logic [TRB-1:0] r_taps [3];

    kcv_pkg::t_reg_idx reg_idx;
    logic              wr_en;
    logic [WB-1:0]     width_used;
    logic [CFB-1:0]    height_used;
    kcv_pkg::t_taps    taps;

    logic                      push, pop, q_valid;
    kcv_pkg::t_job             push_job, pop_job;
    logic [kcv_pkg::Q_CNT-1:0] q_count;

    assign pready  = 1'b1;
    assign reg_idx = kcv_pkg::t_reg_idx'(paddr[kcv_pkg::ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= kcv_pkg::WIDTH_RESET;
            r_frame_height <= kcv_pkg::HEIGHT_RESET;
            r_taps[0]      <= '0;
            r_taps[1]      <= '0;
            r_taps[2]      <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                kcv_pkg::REG_WIDTH:    r_frame_width  <= pwdata[CFB-1:0];
                kcv_pkg::REG_HEIGHT:   r_frame_height <= pwdata[CFB-1:0];
                kcv_pkg::REG_TAPS_TOP: r_taps[0]      <= pwdata[TRB-1:0];
                kcv_pkg::REG_TAPS_MID: r_taps[1]      <= pwdata[TRB-1:0];
                kcv_pkg::REG_TAPS_BOT: r_taps[2]      <= pwdata[TRB-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            kcv_pkg::REG_WIDTH:    prdata = kcv_pkg::DATA_BITS'(r_frame_width);
            kcv_pkg::REG_HEIGHT:   prdata = kcv_pkg::DATA_BITS'(r_frame_height);
            kcv_pkg::REG_TAPS_TOP: prdata = kcv_pkg::DATA_BITS'(r_taps[0]);
            kcv_pkg::REG_TAPS_MID: prdata = kcv_pkg::DATA_BITS'(r_taps[1]);
            kcv_pkg::REG_TAPS_BOT: prdata = kcv_pkg::DATA_BITS'(r_taps[2]);
            default:               prdata = '0;
        endcase
    end

    // Clamp frame size to the supported range
    always_comb begin
        if (r_frame_width < CFB'(3)) begin
            width_used = WB'(3);
        end else if (32'(r_frame_width) > kcv_pkg::MAX_WIDTH) begin
            width_used = WB'(kcv_pkg::MAX_WIDTH);
        end else begin
            width_used = WB'(r_frame_width);
        end
        if (r_frame_height < CFB'(3)) begin
            height_used = CFB'(3);
        end else begin
            height_used = r_frame_height;
        end
    end

    // Unpack taps: entry r*3+c, left tap in the low byte
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                taps[r*3 + c] = r_taps[r][c*TB +: TB];
            end
        end
    end

    kcv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel),
        .i_flush    (i_flush),
        .i_width    (width_used),
        .i_height   (height_used),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_push_job (push_job)
    );

    kcv_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_valid    (q_valid),
        .o_count    (q_count)
    );

    kcv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_taps      (taps),
        .i_q_valid   (q_valid),
        .o_pop       (pop),
        .i_job       (pop_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered),
        .o_frame_end (o_frame_end)
    );

endmodule

### sv/kcv_checker.sv
// Port-level checks of the 3x3 convolution block and their bind.
`include "assert_macros.svh"

module kcv_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [kcv_pkg::PIXEL_BITS-1:0]       i_pixel,
    input logic                                 i_flush,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [kcv_pkg::OUT_BITS-1:0]  o_filtered,
    input logic                                 o_frame_end,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [kcv_pkg::ADDR_BITS-1:0]        paddr,
    input logic [kcv_pkg::DATA_BITS-1:0]        pwdata,
    input logic [kcv_pkg::DATA_BITS-1:0]        prdata,
    input logic                                 pready
);

    logic                        cfg_wr, width_sel, width_wr, out_stall;
    logic [kcv_pkg::OUT_BITS:0]  out_word;

    assign cfg_wr    = psel && penable && pwrite && pready;
    assign width_sel = paddr[kcv_pkg::ADDR_BITS-1:2] == kcv_pkg::REG_WIDTH;
    assign width_wr  = cfg_wr && width_sel;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_frame_end, o_filtered};

    property p_out_hold;
        out_stall |=> o_out_valid && $stable(out_word);
    endproperty

    property p_width_readback;
        (width_wr ##1 (psel && !pwrite && width_sel))
            |-> prdata[kcv_pkg::CFG_BITS-1:0] == $past(pwdata[kcv_pkg::CFG_BITS-1:0]);
    endproperty

    // A stalled result holds its word
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result changed")

    // Reset empties the output register
    `ASSERT_ALWAYS(a_rst_out_empty, i_clk, !i_rst_n |=> !o_out_valid, "result present after reset")

    // Reset leaves the queue empty, so input is taken at once
    `ASSERT_ALWAYS(a_rst_in_ready, i_clk, !i_rst_n |=> o_in_ready, "input not ready after reset")

    // A width write reads back on the next cycle
    `ASSERT_RST(a_width_readback, i_clk, i_rst_n, p_width_readback, "width readback mismatch")

endmodule

bind kernel_convolution_3x3 kcv_checker u_kcv_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the 3x3 convolution block: predicted window sums vs. results.
module tb_top;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_WORDS  = 850;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    // Register index past the last one; writes to it are ignored
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef enum {FILL_RANDOM, FILL_FULL} t_fill;

    typedef struct {
        logic signed [kcv_pkg::OUT_BITS-1:0] filtered;
        logic                                frame_end;
    } t_filtered_word;

    // Predicts the window sums and holds them until the block returns them
    class t_window_sum_checker;
        bit [kcv_pkg::CFG_BITS-1:0]      width_reg;
        bit [kcv_pkg::CFG_BITS-1:0]      height_reg;
        bit [kcv_pkg::TAPS_ROW_BITS-1:0] taps_reg[3];
        bit [kcv_pkg::PIXEL_BITS-1:0]    upper_row[kcv_pkg::MAX_WIDTH];
        bit [kcv_pkg::PIXEL_BITS-1:0]    middle_row[kcv_pkg::MAX_WIDTH];
        bit [kcv_pkg::PIXEL_BITS-1:0]    win[3][3];
        int unsigned                     in_col, in_row, out_col, out_row;
        t_filtered_word                  expected_sums[$];
        int                              errors;

        function new();
            width_reg  = kcv_pkg::WIDTH_RESET;
            height_reg = kcv_pkg::HEIGHT_RESET;
        endfunction

        function int unsigned used_width();
            int unsigned w;
            w = 32'(width_reg);
            if (w < 3) w = 3;
            if (w > kcv_pkg::MAX_WIDTH) w = kcv_pkg::MAX_WIDTH;
            return w;
        endfunction

        function int unsigned used_height();
            int unsigned h;
            h = 32'(height_reg);
            if (h < 3) h = 3;
            if (h > kcv_pkg::MAX_HEIGHT) h = kcv_pkg::MAX_HEIGHT;
            return h;
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [kcv_pkg::DATA_BITS-1:0] value);
            case (idx)
                kcv_pkg::REG_WIDTH:    width_reg   = value[kcv_pkg::CFG_BITS-1:0];
                kcv_pkg::REG_HEIGHT:   height_reg  = value[kcv_pkg::CFG_BITS-1:0];
                kcv_pkg::REG_TAPS_TOP: taps_reg[0] = value[kcv_pkg::TAPS_ROW_BITS-1:0];
                kcv_pkg::REG_TAPS_MID: taps_reg[1] = value[kcv_pkg::TAPS_ROW_BITS-1:0];
                kcv_pkg::REG_TAPS_BOT: taps_reg[2] = value[kcv_pkg::TAPS_ROW_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel_word(logic [kcv_pkg::PIXEL_BITS-1:0] pixel, logic flush);
            int unsigned                  w, h, col;
            int                           r, c, sum, pix_v, tap_v;
            bit                           draining, emit, last;
            bit [kcv_pkg::PIXEL_BITS-1:0] px;
            t_filtered_word               res;
            w = used_width();
            h = used_height();
            draining = (in_row >= h);
            // drop flush words inside the frame
            if (flush && !draining) return;
            px = draining ? '0 : pixel;
            col = (in_col >= kcv_pkg::MAX_WIDTH) ? 0 : in_col;

            // shift the window left and load the new column
            for (r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = upper_row[col];
            win[1][2] = middle_row[col];
            win[2][2] = px;
            upper_row[col]  = win[1][2];
            middle_row[col] = px;

            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

            // advance the input position
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row++;
            end else begin
                in_col++;
            end
            if (!emit) return;

            // weighted sum inside, plain center pixel on the border
            if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
                sum = 0;
                for (r = 0; r < 3; r++) begin
                    for (c = 0; c < 3; c++) begin
                        pix_v = int'(win[r][c]);
                        tap_v = int'($signed(taps_reg[r][kcv_pkg::TAP_BITS*c +: kcv_pkg::TAP_BITS]));
                        sum += pix_v * tap_v;
                    end
                end
            end else begin
                sum = int'(win[1][1]);
            end
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.filtered  = sum[kcv_pkg::OUT_BITS-1:0];
            res.frame_end = last;
            expected_sums.push_back(res);

            // advance the output position, rewind all at frame end
            if (last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        function void check_filtered(logic signed [kcv_pkg::OUT_BITS-1:0] filtered,
                                     logic frame_end);
            t_filtered_word exp_w;
            if (expected_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: filtered %0d frame_end %0b",
                         $time, filtered, frame_end);
                return;
            end
            exp_w = expected_sums.pop_front();
            if (filtered !== exp_w.filtered) begin
                errors++;
                $display("%0t: filtered mismatch: expected %0d, actual %0d",
                         $time, exp_w.filtered, filtered);
            end
            if (frame_end !== exp_w.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                         $time, exp_w.frame_end, frame_end);
            end
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic [kcv_pkg::PIXEL_BITS-1:0]       i_pixel;
    logic                                 i_flush;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic signed [kcv_pkg::OUT_BITS-1:0]  o_filtered;
    logic                                 o_frame_end;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [kcv_pkg::ADDR_BITS-1:0]        paddr;
    logic [kcv_pkg::DATA_BITS-1:0]        pwdata;
    logic [kcv_pkg::DATA_BITS-1:0]        prdata;
    logic                                 pready;

    t_window_sum_checker sum_checker = new();
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  cycle_count = 0;

    kernel_convolution_3x3 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .i_flush     (i_flush),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Predict on accepted pixel words, check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sum_checker.take_pixel_word(i_pixel, i_flush);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sum_checker.check_filtered(o_filtered, o_frame_end);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("kernel_convolution_3x3 test failed");
            $finish;
        end
    end

    task automatic send_word(input logic [kcv_pkg::PIXEL_BITS-1:0] pixel, input logic flush);
        // idle the input channel at random before this word
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= pixel;
        i_flush    <= flush;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sum_checker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx,
                             input logic [kcv_pkg::DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= kcv_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sum_checker.set_reg(idx, value);
    endtask

    // Write all registers, unused upper bits random
    task automatic program_frame(input logic [kcv_pkg::CFG_BITS-1:0] w_raw,
                                 input logic [kcv_pkg::CFG_BITS-1:0] h_raw,
                                 input logic [kcv_pkg::TAPS_ROW_BITS-1:0] top,
                                 input logic [kcv_pkg::TAPS_ROW_BITS-1:0] mid,
                                 input logic [kcv_pkg::TAPS_ROW_BITS-1:0] bot);
        write_reg(kcv_pkg::REG_WIDTH, {20'($urandom()), w_raw});
        write_reg(kcv_pkg::REG_HEIGHT, {20'($urandom()), h_raw});
        write_reg(kcv_pkg::REG_TAPS_TOP, {8'($urandom()), top});
        write_reg(kcv_pkg::REG_TAPS_MID, {8'($urandom()), mid});
        write_reg(kcv_pkg::REG_TAPS_BOT, {8'($urandom()), bot});
        if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [kcv_pkg::TAPS_ROW_BITS-1:0] random_taps();
        logic [kcv_pkg::TAPS_ROW_BITS-1:0] row;
        int k;
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(7))
                0: row[8*k +: 8] = 8'h80;
                1: row[8*k +: 8] = 8'h7F;
                2: row[8*k +: 8] = 8'hFF;
                default: row[8*k +: 8] = 8'($urandom());
            endcase
        end
        return row;
    endfunction

    // One whole frame and its drain; count the words that the block uses
    task automatic send_frame(input t_fill fill, input int noise_pct, inout int words);
        int unsigned                    w, h, n;
        logic [kcv_pkg::PIXEL_BITS-1:0] px;
        w = sum_checker.used_width();
        h = sum_checker.used_height();
        // pixels, with stray flush words that the block ignores
        for (n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < noise_pct) send_word(8'($urandom()), 1'b1);
            px = (fill == FILL_FULL) ? '1 : 8'($urandom());
            send_word(px, 1'b0);
        end
        // drain: mostly flush words, some pixels that are taken as zero
        for (n = 0; n <= w; n++) begin
            send_word(8'($urandom()), ($urandom_range(4) != 0));
        end
        words += w * h + w + 1;
    endtask

    initial begin
        int                             words;
        int                             unused_words;
        int                             n;
        int                             phase;
        logic [kcv_pkg::CFG_BITS-1:0]   w_raw;
        logic [kcv_pkg::CFG_BITS-1:0]   h_raw;

        words        = 0;
        unused_words = 0;
        send_idle_pct = 32;
        recv_idle_pct = 57;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pixel     <= '0;
        i_flush     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame, all taps most negative, all pixels full scale
        program_frame(12'd3, 12'd0, 24'h808080, 24'h808080, 24'h808080);
        for (n = 0; n < 9; n++) begin
            // flush inside the frame is ignored
            if (n == 4) send_word(8'h00, 1'b1);
            send_word(8'hFF, 1'b0);
        end
        send_word(8'h00, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b1);
        // flush after frame end is ignored too
        send_word(8'h5A, 1'b1);
        wait_idle();

        // Smallest frame again, taps most positive
        program_frame(12'd2, 12'd3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        send_frame(FILL_FULL, 0, unused_words);
        wait_idle();

        // Random frames over the three idling phases
        while (words < RANDOM_WORDS) begin
            phase = words * 3 / RANDOM_WORDS;
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 32 : 0;
            if (words == 0 || $urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0: w_raw = kcv_pkg::CFG_BITS'($urandom_range(2));
                    1: w_raw = kcv_pkg::CFG_BITS'($urandom_range(80, 13));
                    default: w_raw = kcv_pkg::CFG_BITS'($urandom_range(12, 3));
                endcase
                h_raw = ($urandom_range(7) == 0) ? kcv_pkg::CFG_BITS'($urandom_range(2))
                                                 : kcv_pkg::CFG_BITS'($urandom_range(7, 3));
                wait_idle();
                program_frame(w_raw, h_raw, random_taps(), random_taps(), random_taps());
            end
            send_frame(FILL_RANDOM, 5, words);
            if ($urandom_range(5) == 0) send_word(8'($urandom()), 1'b1);
        end

        wait_idle();
        if (sum_checker.errors == 0 && sum_checker.pending() == 0) begin
            $display("kernel_convolution_3x3 test passed");
        end else begin
            $display("kernel_convolution_3x3 test failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/kcv_pkg.sv
sv/kcv_ram.sv
sv/kcv_front.sv
sv/kcv_fifo.sv
sv/kcv_back.sv
sv/kernel_convolution_3x3.sv
sv/kcv_checker.sv
tb/tb_top.sv
